// ===== rtl/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int unsigned COORD_BITS  = 7;
  localparam int unsigned ERR_BITS    = COORD_BITS + 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // Command handed from the front end to the stepping engine.
  typedef struct packed {
    action_e act;
    logic    steep;
    coord_t  major_pos;
    coord_t  major_end;
    coord_t  minor_pos;
    logic    minor_down;
    coord_t  major_delta;
    coord_t  minor_delta;
  } line_cmd_t;

endpackage

// ===== rtl/brl_front.sv =====
// ----------------------------------------------------------------------------
// brl_front
// Classifies an input beat and, for a load, works out the line setup:
// axis swap for steep lines, endpoint order along the major axis, deltas.
// ----------------------------------------------------------------------------
module brl_front (
  input  logic              action_i,
  input  brl_pkg::coord_t   start_x_i,
  input  brl_pkg::coord_t   start_y_i,
  input  brl_pkg::coord_t   end_x_i,
  input  brl_pkg::coord_t   end_y_i,
  output brl_pkg::line_cmd_t cmd_o
);
  import brl_pkg::*;

  coord_t dx, dy;
  logic   steep;
  coord_t a_maj, a_min, b_maj, b_min;
  coord_t p0_maj, p0_min, p1_maj, p1_min;

  always_comb begin
    dx = (start_x_i > end_x_i) ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    dy = (start_y_i > end_y_i) ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    steep = (dy > dx);

    a_maj = steep ? start_y_i : start_x_i;
    a_min = steep ? start_x_i : start_y_i;
    b_maj = steep ? end_y_i   : end_x_i;
    b_min = steep ? end_x_i   : end_y_i;

    // order endpoints so the major coordinate increases
    if (a_maj > b_maj) begin
      p0_maj = b_maj;
      p0_min = b_min;
      p1_maj = a_maj;
      p1_min = a_min;
    end else begin
      p0_maj = a_maj;
      p0_min = a_min;
      p1_maj = b_maj;
      p1_min = b_min;
    end

    cmd_o.act         = action_e'(action_i);
    cmd_o.steep       = steep;
    cmd_o.major_pos   = p0_maj;
    cmd_o.major_end   = p1_maj;
    cmd_o.minor_pos   = p0_min;
    cmd_o.minor_down  = (p0_min > p1_min);
    cmd_o.major_delta = p1_maj - p0_maj;
    cmd_o.minor_delta = (p0_min > p1_min) ? (p0_min - p1_min) : (p1_min - p0_min);
  end

endmodule

// ===== rtl/brl_queue.sv =====
// ----------------------------------------------------------------------------
// brl_queue
// Short command queue between the front end and the stepping engine.
// ----------------------------------------------------------------------------
module brl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  brl_pkg::line_cmd_t push_cmd_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output brl_pkg::line_cmd_t pop_cmd_o
);
  import brl_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  line_cmd_t         mem_q [QUEUE_DEPTH];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              do_push, do_pop;

  assign full_o    = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/brl_back.sv =====
// ----------------------------------------------------------------------------
// brl_back
// Stepping engine: holds the active line, walks it one pixel per step
// command and drives the registered pixel output.
// ----------------------------------------------------------------------------
module brl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  brl_pkg::line_cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brl_pkg::coord_t    pixel_x_o,
  output brl_pkg::coord_t    pixel_y_o,
  output logic               last_pixel_o
);
  import brl_pkg::*;

  logic   active_q, active_d;
  logic   steep_q, steep_d;
  coord_t major_pos_q, major_pos_d;
  coord_t major_end_q, major_end_d;
  coord_t minor_pos_q, minor_pos_d;
  logic   minor_down_q, minor_down_d;
  coord_t major_delta_q, major_delta_d;
  coord_t minor_delta_q, minor_delta_d;
  err_t   err_q, err_d;

  logic   out_valid_q, out_valid_d;
  coord_t pix_x_q, pix_x_d;
  coord_t pix_y_q, pix_y_d;
  logic   last_q, last_d;

  logic   out_ready;
  logic   is_last;
  logic   emit;
  err_t   err_sub;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = cmd_valid_i && out_ready;
  assign is_last   = (major_pos_q == major_end_q);
  assign emit      = cmd_pop_o && (cmd_i.act == ACT_STEP) && active_q;
  assign err_sub   = err_q - err_t'({{(ERR_BITS-COORD_BITS){1'b0}}, minor_delta_q});

  always_comb begin
    active_d      = active_q;
    steep_d       = steep_q;
    major_pos_d   = major_pos_q;
    major_end_d   = major_end_q;
    minor_pos_d   = minor_pos_q;
    minor_down_d  = minor_down_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    err_d         = err_q;
    pix_x_d       = pix_x_q;
    pix_y_d       = pix_y_q;
    last_d        = last_q;
    out_valid_d   = out_ready ? 1'b0 : out_valid_q;

    if (cmd_pop_o && (cmd_i.act == ACT_LOAD)) begin
      // abandon any line in progress
      active_d      = 1'b1;
      steep_d       = cmd_i.steep;
      major_pos_d   = cmd_i.major_pos;
      major_end_d   = cmd_i.major_end;
      minor_pos_d   = cmd_i.minor_pos;
      minor_down_d  = cmd_i.minor_down;
      major_delta_d = cmd_i.major_delta;
      minor_delta_d = cmd_i.minor_delta;
      err_d         = err_t'({{(ERR_BITS-COORD_BITS+1){1'b0}},
                              cmd_i.major_delta[COORD_BITS-1:1]});
    end else if (emit) begin
      out_valid_d = 1'b1;
      pix_x_d     = steep_q ? minor_pos_q : major_pos_q;
      pix_y_d     = steep_q ? major_pos_q : minor_pos_q;
      last_d      = is_last;
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        major_pos_d = major_pos_q + 1'b1;
        if (err_sub[ERR_BITS-1]) begin
          // error went negative: take a minor step
          minor_pos_d = minor_down_q ? (minor_pos_q - 1'b1) : (minor_pos_q + 1'b1);
          err_d       = err_sub + err_t'({{(ERR_BITS-COORD_BITS){1'b0}}, major_delta_q});
        end else begin
          err_d = err_sub;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      steep_q       <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      minor_down_q  <= 1'b0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      err_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      active_q      <= active_d;
      steep_q       <= steep_d;
      major_pos_q   <= major_pos_d;
      major_end_q   <= major_end_d;
      minor_pos_q   <= minor_pos_d;
      minor_down_q  <= minor_down_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      err_q         <= err_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_x_q <= pix_x_d;
    pix_y_q <= pix_y_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign last_pixel_o = last_q;

  // error term stays within [0, major_delta] while a line is active
  a_err_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !err_q[ERR_BITS-1])
    else $error("error term negative on active line");

  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (err_q <= err_t'({{(ERR_BITS-COORD_BITS){1'b0}}, major_delta_q})))
    else $error("error term above major delta");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> (!active_q && out_valid_q && last_q))
    else $error("line still active after final pixel");

  a_no_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && !active_q) |=> !out_valid_q)
    else $error("pixel emitted with no active line");

endmodule

// ===== rtl/bresenham_line_raster_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_raster_core
// Integer Bresenham line rasterizer with decoupled setup and stepping.
// ----------------------------------------------------------------------------
// A load beat (action 0) sets up a line between two endpoints, both included;
// each step beat (action 1) emits the next pixel, with last_pixel marking the
// final end point, and a step with no active line emits nothing. The block
// takes one beat per clock unless the queue is full: the front end does the
// load setup in the accept cycle, a two-entry command queue carries beats in
// order, and the stepping engine handles one command per cycle unless the
// output stalls, with one subtract, add, compare and minor step. A pixel goes
// through the queue and the output register, which holds it while the consumer stalls.
// ----------------------------------------------------------------------------
module bresenham_line_raster_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            action_i,
  input  brl_pkg::coord_t start_x_i,
  input  brl_pkg::coord_t start_y_i,
  input  brl_pkg::coord_t end_x_i,
  input  brl_pkg::coord_t end_y_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output brl_pkg::coord_t pixel_x_o,
  output brl_pkg::coord_t pixel_y_o,
  output logic            last_pixel_o
);
  import brl_pkg::*;

  line_cmd_t front_cmd;
  line_cmd_t queue_cmd;
  logic      queue_full;
  logic      queue_valid;
  logic      queue_pop;

  brl_front u_front (
    .action_i  (action_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .cmd_o     (front_cmd)
  );

  brl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .valid_o    (queue_valid),
    .pop_i      (queue_pop),
    .pop_cmd_o  (queue_cmd)
  );

  brl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  assign in_stall_o = queue_full;

endmodule

// ===== tb/sv/bresenham_line_raster_core_tb.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_raster_core_tb
// Self-checking bench for the line rasterizer: drives load and step beats with
// random gaps, stalls the pixel stream at random and compares every pixel with
// a cycle-free prediction of the walk along the line.
// ----------------------------------------------------------------------------
module bresenham_line_raster_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RAND_BEATS  = 550;

  // Predicts the pixel sequence and holds the pixels still owed by the block.
  class pixel_scoreboard;
    typedef struct packed {
      coord_t x;
      coord_t y;
      logic   last;
    } pixel_t;

    pixel_t      owed_q[$];
    int unsigned mismatches = 0;

    bit     active     = 1'b0;
    bit     steep      = 1'b0;
    bit     minor_down = 1'b0;
    coord_t major_pos  = '0;
    coord_t major_end  = '0;
    coord_t minor_pos  = '0;
    coord_t major_dlt  = '0;
    coord_t minor_dlt  = '0;
    err_t   err        = '0;

    function void note_beat(action_e act, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      coord_t ax, ay, bx, by, t;
      coord_t dx, dy;
      pixel_t px;
      if (act == ACT_LOAD) begin
        ax = sx;
        ay = sy;
        bx = ex;
        by = ey;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        steep = (dy > dx);
        if (steep) begin
          t = ax; ax = ay; ay = t;
          t = bx; bx = by; by = t;
        end
        // walk the major axis upward
        if (ax > bx) begin
          t = ax; ax = bx; bx = t;
          t = ay; ay = by; by = t;
        end
        major_pos  = ax;
        major_end  = bx;
        minor_pos  = ay;
        minor_down = (ay > by);
        major_dlt  = bx - ax;
        minor_dlt  = (ay > by) ? ay - by : by - ay;
        err        = err_t'({2'b00, major_dlt >> 1});
        active     = 1'b1;
      end else if (active) begin
        px.last = (major_pos == major_end);
        px.x    = steep ? minor_pos : major_pos;
        px.y    = steep ? major_pos : minor_pos;
        owed_q.push_back(px);
        if (px.last) begin
          active = 1'b0;
        end else begin
          err = err - err_t'({2'b00, minor_dlt});
          if (err < 0) begin
            minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
            err       = err + err_t'({2'b00, major_dlt});
          end
          major_pos = major_pos + 1'b1;
        end
      end
    endfunction

    function void check_pixel(coord_t x, coord_t y, logic last);
      pixel_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: x=%0d y=%0d last=%0b", x, y, last);
      end else begin
        want = owed_q.pop_front();
        if (want.x !== x || want.y !== y || want.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     want.x, want.y, want.last, x, y, last);
        end
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_stall_o;
  logic   action_i     = 1'b0;
  coord_t start_x_i    = '0;
  coord_t start_y_i    = '0;
  coord_t end_x_i      = '0;
  coord_t end_y_i      = '0;
  logic   out_valid_o;
  logic   out_stall_i  = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  pixel_scoreboard sb = new();
  bit              no_idle    = 1'b0;
  int unsigned     beats_sent = 0;
  int unsigned     cycle_cnt  = 0;

  bresenham_line_raster_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t rnd_coord();
    return coord_t'($urandom_range(0, 127));
  endfunction

  function automatic coord_t near_coord(coord_t c);
    int lo, hi;
    lo = (c > 8) ? int'(c) - 8 : 0;
    hi = (c < 119) ? int'(c) + 8 : 127;
    return coord_t'($urandom_range(lo, hi));
  endfunction

  function automatic int line_len(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int dx, dy;
    dx = (sx > ex) ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
    dy = (sy > ey) ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  task automatic push_beat(action_e act, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    beats_sent++;
  endtask

  // Load a line, then request a number of pixels; step payloads are don't-care.
  task automatic send_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey, int steps);
    push_beat(ACT_LOAD, sx, sy, ex, ey);
    repeat (steps) push_beat(ACT_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  // Output stall pattern: stall bursts of random length between free runs.
  initial begin : stall_gen
    int unsigned stall_n, free_n;
    forever begin
      stall_n = idle_len();
      free_n  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      repeat (stall_n) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
      end
      repeat (free_n) begin
        @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_stall_o === 1'b0)
      sb.note_beat(action_e'(action_i), start_x_i, start_y_i, end_x_i, end_y_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_pixel(pixel_x_o, pixel_y_o, last_pixel_o);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt, sb.pending());
      $display("FAIL bresenham_line_raster_core");
      $finish;
    end
  end

  initial begin : stimulus
    coord_t sx, sy, ex, ey;
    int     n, steps, pick, tail;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // step with nothing loaded: ignored
    push_beat(ACT_STEP, 7'd127, 7'd127, 7'd127, 7'd127);
    // single point, then steps past its end
    send_line(7'd127, 7'd0, 7'd127, 7'd0, 3);
    // shallow, endpoints given right to left, minor axis rises along the walk
    send_line(7'd127, 7'd127, 7'd124, 7'd125, 4);
    // steep, swapped axes with decreasing minor
    send_line(7'd0, 7'd127, 7'd1, 7'd124, 4);
    // horizontal line cut short by a new load
    send_line(7'd0, 7'd0, 7'd3, 7'd0, 2);
    // vertical line with one extra step
    send_line(7'd126, 7'd0, 7'd126, 7'd2, 4);

    beats_sent = 0;
    while (beats_sent < RAND_BEATS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 78) begin
        sx = rnd_coord();
        sy = rnd_coord();
        if ($urandom_range(0, 9) < 9) begin
          ex = near_coord(sx);
          ey = near_coord(sy);
        end else begin
          ex = rnd_coord();
          ey = rnd_coord();
        end
        n    = line_len(sx, sy, ex, ey);
        tail = $urandom_range(0, 9);
        if (tail < 7)
          steps = n;
        else if (tail < 9)
          steps = n + $urandom_range(1, 3);
        else
          steps = $urandom_range(0, n - 1);
        send_line(sx, sy, ex, ey, steps);
      end else begin
        repeat ($urandom_range(1, 4))
          push_beat(action_e'($urandom_range(0, 1)), rnd_coord(), rnd_coord(),
                    rnd_coord(), rnd_coord());
      end
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("PASS bresenham_line_raster_core");
    else
      $display("FAIL bresenham_line_raster_core");
    $finish;
  end

endmodule
